// File: hdl/ccpc_pkg.sv
// shared types and constants for the clip crossfade playback controller
`default_nettype none
package ccpc_pkg;

   localparam int MAX_CLIPS_DEFAULT = 16;
   localparam logic [16:0] ALPHA_ONE = 17'h10000;
   localparam logic signed [8:0] CLIP_NONE = -9'sd1;
   localparam int DIV_W = 48;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_SELECT = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RD,
      ST_MUL,
      ST_ADD,
      ST_DIV,
      ST_DFIN,
      ST_FIN,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

// File: hdl/ccpc_req_if.sv
// request channel: one command beat
`default_nettype none
interface ccpc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic [7:0]         clip_index;
   logic [31:0]        clip_length;
   logic signed [15:0] play_rate;
   logic               looping;
   logic [31:0]        blend_time;
   logic [31:0]        delta_time;

   modport source (output valid, cmd, clip_index, clip_length, play_rate, looping,
                   blend_time, delta_time, input ready);
   modport sink (input valid, cmd, clip_index, clip_length, play_rate, looping,
                 blend_time, delta_time, output ready);
endinterface
`default_nettype wire

// File: hdl/ccpc_rsp_if.sv
// response channel: one status beat per command
`default_nettype none
interface ccpc_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [8:0] current_clip;
   logic signed [8:0] next_clip;
   logic [31:0]       playhead_a;
   logic [31:0]       playhead_b;
   logic [16:0]       fade_alpha;
   logic              playing;
   logic              table_full;

   modport source (output valid, current_clip, next_clip, playhead_a, playhead_b,
                   fade_alpha, playing, table_full, input ready);
   modport sink (input valid, current_clip, next_clip, playhead_a, playhead_b,
                 fade_alpha, playing, table_full, output ready);
endinterface
`default_nettype wire

// File: hdl/clip_crossfade_playback_controller_top.sv
// clip crossfade playback controller with one shared restoring divider
//
//   channel   dir   beat
//   req_bus   in    one command: load, select or tick
//   rsp_bus   out   one status beat after each command
//
// load and select pass through the exec state to the response beat
// a tick reads, multiplies and adds for each active playhead, reduces a looping playhead modulo its length,
// and computes the fade step, both in the 48-step bit-serial divider shared by modulo and alpha step
// reset is synchronous and clears indices, playheads, fade and clip count
// the block takes no new command until its response beat is taken
`default_nettype none
module clip_crossfade_playback_controller_top #(
   parameter int MAX_CLIPS = ccpc_pkg::MAX_CLIPS_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   ccpc_req_if.sink   req_bus,
   ccpc_rsp_if.source rsp_bus
);
   import ccpc_pkg::*;

   localparam int IDX_W = (MAX_CLIPS > 1) ? $clog2(MAX_CLIPS) : 1;
   localparam int CNT_W = $clog2(MAX_CLIPS + 1);

   state_type state_ff, state_in;

   cmd_type            cmd_ff;
   logic [7:0]         idx_ff;
   logic [31:0]        ilen_ff;
   logic signed [15:0] irate_ff;
   logic               iloop_ff;
   logic [31:0]        blend_ff;
   logic [31:0]        delta_ff;

   logic [31:0]        len_mem [MAX_CLIPS];
   logic signed [15:0] rate_mem [MAX_CLIPS];
   logic               loop_mem [MAX_CLIPS];
   logic [31:0]        m_len_ff;
   logic signed [15:0] m_rate_ff;
   logic               m_loop_ff;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic signed [8:0]  cur_ff, cur_in, nxt_ff, nxt_in;
   logic [31:0]        ta_ff, ta_in, tb_ff, tb_in;
   logic [16:0]        alpha_ff, alpha_in;
   logic [31:0]        dur_ff, dur_in;
   logic               full_ff, full_in;

   logic               head_ff, head_in;
   logic signed [48:0] prod_ff, prod_in;
   logic [DIV_W-1:0]   q_ff, q_in;
   logic [31:0]        rem_ff, rem_in;
   logic [31:0]        dvs_ff, dvs_in;
   logic               op_mod_ff, op_mod_in;
   logic               neg_ff, neg_in;
   logic [5:0]         cnt_ff, cnt_in;

   logic               is_full, cur_ok, nxt_ok;
   logic [IDX_W-1:0]   rd_addr;
   logic [31:0]        t_old;
   logic signed [40:0] move;
   logic signed [41:0] nt;
   logic [41:0]        nt_abs;
   logic [31:0]        clamp_val, mod_val, head_val;
   logic               head_done, use_mod;
   logic [32:0]        shifted, trial;
   logic [16:0]        inc;
   state_type          after_head;

   assign is_full  = (count_ff == CNT_W'(MAX_CLIPS));
   assign cur_ok   = (cur_ff != CLIP_NONE);
   assign nxt_ok   = (nxt_ff != CLIP_NONE);
   assign rd_addr  = head_ff ? nxt_ff[IDX_W-1:0] : cur_ff[IDX_W-1:0];
   assign t_old    = head_ff ? tb_ff : ta_ff;
   assign move     = prod_ff[48:8];
   assign nt       = $signed({10'b0, t_old}) + $signed({move[40], move});
   assign nt_abs   = nt[41] ? 42'(-nt) : 42'(nt);
   assign use_mod  = (m_len_ff != 32'd0) && m_loop_ff;
   assign clamp_val = (m_len_ff == 32'd0) ? 32'd0 :
                      nt[41] ? 32'd0 :
                      ($unsigned(nt) > {10'b0, m_len_ff}) ? m_len_ff : nt[31:0];
   assign mod_val  = (neg_ff && rem_ff != 32'd0) ? (m_len_ff - rem_ff) : rem_ff;
   assign head_done = ((state_ff == ST_ADD) && !use_mod) ||
                      ((state_ff == ST_DFIN) && op_mod_ff);
   assign head_val = (state_ff == ST_ADD) ? clamp_val : mod_val;
   assign shifted  = {rem_ff, q_ff[DIV_W-1]};
   assign trial    = shifted - {1'b0, dvs_ff};
   assign inc      = (q_ff > DIV_W'(ALPHA_ONE)) ? ALPHA_ONE : q_ff[16:0];

   always_comb begin
      if (!head_ff && nxt_ok) begin
         after_head = ST_RD;
      end else if (head_ff) begin
         after_head = (dur_ff == 32'd0) ? ST_FIN : ST_DIV;
      end else begin
         after_head = ST_OUT;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_bus.valid) state_in = ST_EXEC;
         ST_EXEC: begin
            if (cmd_ff == CMD_TICK) begin
               if (cur_ok || nxt_ok) state_in = ST_RD;
               else state_in = ST_OUT;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_RD:   state_in = ST_MUL;
         ST_MUL:  state_in = ST_ADD;
         ST_ADD:  state_in = use_mod ? ST_DIV : after_head;
         ST_DIV:  if (cnt_ff == 6'd0) state_in = ST_DFIN;
         ST_DFIN: state_in = op_mod_ff ? after_head : ST_FIN;
         ST_FIN:  state_in = ST_OUT;
         ST_OUT:  if (rsp_bus.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_bus.ready = 1'b0;
      rsp_bus.valid = 1'b0;
      case (state_ff)
         ST_IDLE: req_bus.ready = 1'b1;
         ST_OUT:  rsp_bus.valid = 1'b1;
         default: begin
            req_bus.ready = 1'b0;
            rsp_bus.valid = 1'b0;
         end
      endcase
   end

   assign rsp_bus.current_clip = cur_ff;
   assign rsp_bus.next_clip    = nxt_ff;
   assign rsp_bus.playhead_a   = ta_ff;
   assign rsp_bus.playhead_b   = tb_ff;
   assign rsp_bus.fade_alpha   = alpha_ff;
   assign rsp_bus.playing      = cur_ok || nxt_ok;
   assign rsp_bus.table_full   = full_ff;

   // datapath next values
   always_comb begin
      count_in  = count_ff;
      cur_in    = cur_ff;
      nxt_in    = nxt_ff;
      ta_in     = ta_ff;
      tb_in     = tb_ff;
      alpha_in  = alpha_ff;
      dur_in    = dur_ff;
      full_in   = full_ff;
      head_in   = head_ff;
      prod_in   = prod_ff;
      q_in      = q_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      op_mod_in = op_mod_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      case (state_ff)
         ST_EXEC: begin
            full_in = 1'b0;
            head_in = !cur_ok;
            case (cmd_ff)
               CMD_LOAD: begin
                  if (is_full) full_in = 1'b1;
                  else count_in = count_ff + CNT_W'(1);
               end
               CMD_SELECT: begin
                  if ({1'b0, idx_ff} >= 9'(count_ff)) begin
                     nxt_in   = CLIP_NONE;
                     alpha_in = 17'd0;
                     dur_in   = 32'd0;
                  end else if (!cur_ok || blend_ff == 32'd0) begin
                     cur_in   = $signed({1'b0, idx_ff});
                     nxt_in   = CLIP_NONE;
                     alpha_in = 17'd0;
                     dur_in   = 32'd0;
                     ta_in    = 32'd0;
                     tb_in    = 32'd0;
                  end else if (cur_ff != $signed({1'b0, idx_ff})) begin
                     nxt_in   = $signed({1'b0, idx_ff});
                     dur_in   = blend_ff;
                     alpha_in = 17'd0;
                     tb_in    = 32'd0;
                  end
               end
               default: full_in = 1'b0;
            endcase
         end
         ST_MUL: prod_in = 49'($signed({1'b0, delta_ff})) * 49'(m_rate_ff);
         ST_ADD: begin
            if (use_mod) begin
               q_in      = {6'b0, nt_abs};
               rem_in    = 32'd0;
               dvs_in    = m_len_ff;
               op_mod_in = 1'b1;
               neg_in    = nt[41];
               cnt_in    = 6'(DIV_W - 1);
            end
         end
         ST_DIV: begin
            if (!trial[32]) begin
               rem_in = trial[31:0];
               q_in   = {q_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[31:0];
               q_in   = {q_ff[DIV_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
         end
         ST_DFIN: if (!op_mod_ff) alpha_in = alpha_ff + inc;
         ST_FIN: begin
            if (alpha_ff >= ALPHA_ONE) begin
               cur_in   = nxt_ff;
               ta_in    = tb_ff;
               nxt_in   = CLIP_NONE;
               alpha_in = 17'd0;
               dur_in   = 32'd0;
               tb_in    = 32'd0;
            end
         end
         default: cnt_in = cnt_ff;
      endcase
      if (head_done) begin
         if (head_ff) tb_in = head_val;
         else ta_in = head_val;
         if (!head_ff && nxt_ok) begin
            head_in = 1'b1;
         end else if (head_ff) begin
            if (dur_ff == 32'd0) begin
               alpha_in = ALPHA_ONE;
            end else begin
               q_in      = {delta_ff, 16'b0};
               rem_in    = 32'd0;
               dvs_in    = dur_ff;
               op_mod_in = 1'b0;
               cnt_in    = 6'(DIV_W - 1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         cur_ff   <= CLIP_NONE;
         nxt_ff   <= CLIP_NONE;
         ta_ff    <= 32'd0;
         tb_ff    <= 32'd0;
         alpha_ff <= 17'd0;
         dur_ff   <= 32'd0;
         full_ff  <= 1'b0;
         head_ff  <= 1'b0;
         cnt_ff   <= 6'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cur_ff   <= cur_in;
         nxt_ff   <= nxt_in;
         ta_ff    <= ta_in;
         tb_ff    <= tb_in;
         alpha_ff <= alpha_in;
         dur_ff   <= dur_in;
         full_ff  <= full_in;
         head_ff  <= head_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      q_ff      <= q_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      op_mod_ff <= op_mod_in;
      neg_ff    <= neg_in;
      if (state_ff == ST_IDLE && req_bus.valid) begin
         cmd_ff   <= cmd_type'(req_bus.cmd);
         idx_ff   <= req_bus.clip_index;
         ilen_ff  <= req_bus.clip_length;
         irate_ff <= req_bus.play_rate;
         iloop_ff <= req_bus.looping;
         blend_ff <= req_bus.blend_time;
         delta_ff <= req_bus.delta_time;
      end
   end

   // clip table
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC && cmd_ff == CMD_LOAD && !is_full) begin
         len_mem[count_ff[IDX_W-1:0]]  <= ilen_ff;
         rate_mem[count_ff[IDX_W-1:0]] <= irate_ff;
         loop_mem[count_ff[IDX_W-1:0]] <= iloop_ff;
      end
      if (state_ff == ST_RD) begin
         m_len_ff  <= len_mem[rd_addr];
         m_rate_ff <= rate_mem[rd_addr];
         m_loop_ff <= loop_mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: verif/ccpc_tb_if.sv
// testbench-side beat types for the command and status channels (reuses the block's package types)
`default_nettype none
package ccpc_tb_types;
   import ccpc_pkg::*;

   typedef struct packed {
      cmd_type            cmd;
      logic [7:0]         clip_index;
      logic [31:0]        clip_length;
      logic signed [15:0] play_rate;
      logic               looping;
      logic [31:0]        blend_time;
      logic [31:0]        delta_time;
   } command_beat;

   typedef struct packed {
      logic signed [8:0] current_clip;
      logic signed [8:0] next_clip;
      logic [31:0]       playhead_a;
      logic [31:0]       playhead_b;
      logic [16:0]       fade_alpha;
      logic              playing;
      logic              table_full;
   } status_beat;
endpackage
`default_nettype wire

// File: verif/tb.sv
// self-checking testbench for the clip crossfade playback controller
`default_nettype none
module tb;
   import ccpc_pkg::*;
   import ccpc_tb_types::*;

   localparam int NCLIPS = 16;

   class playback_scoreboard;
      logic [31:0]        len_tab  [NCLIPS];
      logic signed [15:0] rate_tab [NCLIPS];
      logic               loop_tab [NCLIPS];
      int                 n_clips;
      int                 cur, nxt;
      logic [31:0]        head_a, head_b, fade_len;
      logic [16:0]        weight;
      status_beat         pending[$];
      int                 mismatches;

      function new();
         n_clips = 0; cur = -1; nxt = -1;
         head_a = 0; head_b = 0; weight = 0; fade_len = 0;
         mismatches = 0;
      endfunction

      function logic [31:0] move_head(int s, logic [31:0] t, logic [31:0] d);
         longint l, p, m, nt;
         l = longint'(len_tab[s]);
         if (l == 0) return 0;
         p = longint'(d) * longint'(rate_tab[s]);
         m = p >>> 8;
         nt = longint'(t) + m;
         if (loop_tab[s]) begin
            nt = nt % l;
            if (nt < 0) nt += l;
         end else begin
            if (nt < 0) nt = 0;
            if (nt > l) nt = l;
         end
         return nt[31:0];
      endfunction

      function void note_command(command_beat c);
         status_beat s;
         longint unsigned step;
         logic full;
         int ci;
         full = 0;
         ci = int'(c.clip_index);
         case (c.cmd)
            CMD_LOAD: begin
               if (n_clips >= NCLIPS) full = 1;
               else begin
                  len_tab[n_clips] = c.clip_length;
                  rate_tab[n_clips] = c.play_rate;
                  loop_tab[n_clips] = c.looping;
                  n_clips++;
               end
            end
            CMD_SELECT: begin
               if (ci >= n_clips) begin
                  nxt = -1; weight = 0; fade_len = 0;
               end else if (cur == -1 || c.blend_time == 0) begin
                  cur = ci; nxt = -1; weight = 0; fade_len = 0;
                  head_a = 0; head_b = 0;
               end else if (cur != ci) begin
                  nxt = ci; fade_len = c.blend_time;
                  weight = 0; head_b = 0;
               end
            end
            CMD_TICK: begin
               if (cur >= 0) head_a = move_head(cur, head_a, c.delta_time);
               if (nxt >= 0) begin
                  head_b = move_head(nxt, head_b, c.delta_time);
                  if (fade_len == 0) weight = ALPHA_ONE;
                  else begin
                     step = (longint'(c.delta_time) << 16) / longint'(fade_len);
                     if (step > 64'(ALPHA_ONE)) step = 64'(ALPHA_ONE);
                     weight = weight + step[16:0];
                  end
                  if (weight >= ALPHA_ONE) begin
                     cur = nxt; head_a = head_b;
                     nxt = -1; weight = 0; fade_len = 0; head_b = 0;
                  end
               end
            end
            default: ;
         endcase
         s.current_clip = cur[8:0];
         s.next_clip = nxt[8:0];
         s.playhead_a = head_a;
         s.playhead_b = head_b;
         s.fade_alpha = weight;
         s.playing = (cur != -1 || nxt != -1);
         s.table_full = full;
         pending.push_back(s);
      endfunction

      function void check_status(status_beat got);
         status_beat want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected status beat %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("status mismatch: expected %p actual %p", want, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   ccpc_req_if req_bus();
   ccpc_rsp_if rsp_bus();
   playback_scoreboard board;
   bit steady_phase;

   clip_crossfade_playback_controller_top #(.MAX_CLIPS(NCLIPS)) DUT (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_bus.valid = 0; req_bus.cmd = 0; req_bus.clip_index = 0;
      req_bus.clip_length = 0; req_bus.play_rate = 0; req_bus.looping = 0;
      req_bus.blend_time = 0; req_bus.delta_time = 0;
      rsp_bus.ready = 0;
   end

   // sink side: random back-pressure and checking
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_status({rsp_bus.current_clip, rsp_bus.next_clip, rsp_bus.playhead_a,
                             rsp_bus.playhead_b, rsp_bus.fade_alpha, rsp_bus.playing,
                             rsp_bus.table_full});
      rsp_bus.ready <= steady_phase || ($urandom_range(99) >= 38);
   end

   // valid stays high after a beat; outside the steady phase random gaps may drop it before the next beat
   task automatic send_command(command_beat c);
      while (!steady_phase && $urandom_range(99) < 38) begin
         req_bus.valid <= 0;
         @(posedge clock);
      end
      req_bus.valid <= 1;
      {req_bus.cmd, req_bus.clip_index, req_bus.clip_length, req_bus.play_rate,
       req_bus.looping, req_bus.blend_time, req_bus.delta_time} <= c;
      do @(posedge clock); while (!req_bus.ready);
      board.note_command(c);
   endtask

   function automatic command_beat make_cmd(cmd_type k, logic [7:0] i, logic [31:0] l,
                                            logic [15:0] r, logic lp, logic [31:0] b,
                                            logic [31:0] d);
      command_beat c;
      c.cmd = k; c.clip_index = i; c.clip_length = l; c.play_rate = r;
      c.looping = lp; c.blend_time = b; c.delta_time = d;
      return c;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(65536 * 8);
         2: return $urandom_range(2048);
         default: return 32'hFFFF_FFFF - $urandom_range(3);
      endcase
   endfunction

   function automatic command_beat random_cmd();
      command_beat c;
      int r;
      c = make_cmd(cmd_type'($urandom_range(3)), 8'($urandom), pick_word(), 16'($urandom),
                   1'($urandom), pick_word(), pick_word());
      r = $urandom_range(99);
      if (r < 8) c.cmd = CMD_LOAD;
      else if (r < 35) c.cmd = CMD_SELECT;
      else if (r < 95) c.cmd = CMD_TICK;
      else c.cmd = CMD_NOP;
      if (c.cmd == CMD_SELECT && $urandom_range(9) < 8)
         c.clip_index = 8'($urandom_range(board.n_clips > 0 ? board.n_clips - 1 : 0));
      if ($urandom_range(3) == 0) c.blend_time = 0;
      return c;
   endfunction

   task automatic drain();
      req_bus.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      board = new();
      steady_phase = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: idle tick, empty select, loads with extreme fields, selects, fades, ticks and a nop
      send_command(make_cmd(CMD_TICK, 0, 0, 0, 0, 0, 32'h0001_0000));
      send_command(make_cmd(CMD_SELECT, 0, 0, 0, 0, 5, 0));
      send_command(make_cmd(CMD_LOAD, 0, 32'h0004_0000, 16'h0100, 1, 0, 0));
      send_command(make_cmd(CMD_LOAD, 0, 32'hFFFF_FFFF, 16'h8000, 0, 0, 0));
      send_command(make_cmd(CMD_LOAD, 0, 0, 16'h7FFF, 1, 0, 0));
      send_command(make_cmd(CMD_LOAD, 0, 32'h0002_0000, 16'hFF00, 1, 0, 0));
      send_command(make_cmd(CMD_SELECT, 0, 0, 0, 0, 32'h0001_0000, 0));
      send_command(make_cmd(CMD_TICK, 0, 0, 0, 0, 0, 32'h0005_8000));
      send_command(make_cmd(CMD_SELECT, 3, 0, 0, 0, 32'h0002_0000, 0));
      send_command(make_cmd(CMD_TICK, 0, 0, 0, 0, 0, 32'h0000_4001));
      send_command(make_cmd(CMD_SELECT, 0, 0, 0, 0, 32'h0002_0000, 0));
      send_command(make_cmd(CMD_TICK, 0, 0, 0, 0, 0, 32'h0000_0001));
      send_command(make_cmd(CMD_TICK, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
      send_command(make_cmd(CMD_SELECT, 1, 0, 0, 0, 32'hFFFF_FFFF, 0));
      send_command(make_cmd(CMD_TICK, 0, 0, 0, 0, 0, 32'h0000_0003));
      send_command(make_cmd(CMD_SELECT, 255, 0, 0, 0, 1, 0));
      send_command(make_cmd(CMD_SELECT, 2, 0, 0, 0, 0, 0));
      send_command(make_cmd(CMD_TICK, 0, 0, 0, 0, 0, 32'h0001_0000));
      send_command(make_cmd(CMD_NOP, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF));
      // fill the table and overflow it
      repeat (14) send_command(make_cmd(CMD_LOAD, 0, pick_word(), 16'($urandom),
                                        1'($urandom), 0, 0));
      drain();
      for (int n = 0; n < 520; n++) begin
         steady_phase = (n >= 200 && n < 260);
         send_command(random_cmd());
         if (n == 300) drain();
      end
      steady_phase = 0;
      drain();
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #20000000;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
